>>> hdl/fdn_pkg.sv
// Shared types, constants and helpers for the eight-line FDN reverb.
// No dependencies; imported by fdn_reverb_eight_line_top.
package fdn_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int NUM_LINES     = 8;
   localparam int LINE_BITS     = 3;
   localparam int COEF_BITS     = 16;
   localparam int CSR_IDX_BITS  = 2;
   localparam int DEF_MAX_DEPTH = 4096;

   localparam logic [COEF_BITS-1:0] GAIN_RESET  = 16'd49152;
   localparam logic [COEF_BITS-1:0] DAMP_RESET  = 16'd65535;
   localparam logic [COEF_BITS-1:0] SCALE_RESET = 16'd16384;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FEEDBACK_GAIN = 2'd0,
      CSR_DAMP_COEFF    = 2'd1,
      CSR_SIZE_SCALE    = 2'd2,
      CSR_STEREO_MODE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_type;

   // prime base length of each line
   function automatic logic [10:0] line_base(input logic [LINE_BITS-1:0] line);
      logic [10:0] b;
      case (line)
         3'd0:    b = 11'd1051;
         3'd1:    b = 11'd1123;
         3'd2:    b = 11'd1277;
         3'd3:    b = 11'd1381;
         3'd4:    b = 11'd1511;
         3'd5:    b = 11'd1657;
         3'd6:    b = 11'd1777;
         default: b = 11'd1913;
      endcase
      return b;
   endfunction

   // clamp a 32-bit signed value to the sample range
   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [31:0] x);
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      hi = 32'sd2 ** (SAMPLE_BITS - 1) - 32'sd1;
      lo = -hi - 32'sd1;
      if (x > hi)
         return hi[SAMPLE_BITS-1:0];
      else if (x < lo)
         return lo[SAMPLE_BITS-1:0];
      else
         return x[SAMPLE_BITS-1:0];
   endfunction

endpackage

>>> hdl/fdn_reverb_eight_line_top.sv
// Eight-line feedback delay network reverb, top level.
// Depends on fdn_pkg (types, constants, saturation and base-length helpers).
//
// Usage:
//  - req channel: one stereo sample pair per transaction (req_valid/req_stall).
//    A transaction completes on a clock edge with req_valid high, req_stall low.
//  - rsp channel: one left/right output pair per input transaction, held in an
//    output register until rsp_stall is low.
//  - csr channel: register writes (csr_valid/csr_ready), index 0 feedback gain,
//    1 damping coefficient, 2 size scale, 3 stereo mode. csr_ready is always high.
// Schedule:
//  - One item at a time. After accept, an item passes through eight reads of the
//    delay memory port, a MIX state that waits out the read latency, then for
//    each line the DAMP, SMOOTH, GAIN and WRITE states (damp multiply, lowpass
//    update, gain multiply, write-back) on separate damp and gain multipliers,
//    then DONE, which loads the output. The next item can be taken once the
//    sequencer is back in IDLE after the load. The single-port delay memory
//    bounds the schedule: every line is one read and one write on it.
// Reset:
//  - Synchronous, active high. The delay memory (8 x MAX_LINE_DEPTH words) is
//    swept to zero, one word per cycle, then the line lengths are computed in
//    the LEN state. req_stall stays high meanwhile.
//  - A size_scale write zeroes the pointers and reruns the length pass.
// Back-pressure:
//  - A stalled result holds; a finished item waits in DONE until the output
//    register is free, and the block takes a new item once it has moved on.
module fdn_reverb_eight_line_top
   import fdn_pkg::*;
#(
   parameter int MAX_LINE_DEPTH = DEF_MAX_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [COEF_BITS-1:0]     csr_data
);

   localparam int MEM_DEPTH = NUM_LINES * MAX_LINE_DEPTH;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int PW        = $clog2(MAX_LINE_DEPTH);
   localparam int LENW      = $clog2(MAX_LINE_DEPTH + 1);
   localparam int SB        = SAMPLE_BITS;

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b0000000001,
      ST_LEN    = 10'b0000000010,
      ST_IDLE   = 10'b0000000100,
      ST_READ   = 10'b0000001000,
      ST_MIX    = 10'b0000010000,
      ST_DAMP   = 10'b0000100000,
      ST_SMOOTH = 10'b0001000000,
      ST_GAIN   = 10'b0010000000,
      ST_WRITE  = 10'b0100000000,
      ST_DONE   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [COEF_BITS-1:0] gain_ff, damp_ff, scale_ff;
   logic                 stereo_ff;
   logic                 len_pend_ff, len_pend_in;

   // per-line state
   logic [PW-1:0]          ptr_ff [NUM_LINES];
   logic [LENW-1:0]        len_ff [NUM_LINES];
   logic signed [SB-1:0]   lp_ff  [NUM_LINES];
   logic signed [SB-1:0]   d_ff   [NUM_LINES];

   // delay memory
   logic signed [SB-1:0] mem [MEM_DEPTH];
   logic signed [SB-1:0] mem_rdata_ff;
   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_addr;
   logic signed [SB-1:0] mem_wdata;

   logic [AW-1:0]          clr_ff;
   logic [LINE_BITS-1:0]   idx_ff;
   logic                   rd_pend_ff;
   logic [LINE_BITS-1:0]   rd_line_ff;
   logic signed [SB-1:0]   mono_ff;
   logic signed [SB+2:0]   total_ff;
   logic signed [SB+1:0]   even_ff, odd_ff;
   logic signed [43:0]     prod1_ff, prod1_in;
   logic signed [SB-1:0]   snew_ff, snew_in;
   logic signed [SB+16:0]  prod2_ff, prod2_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   logic                   accept, csr_we, load_out;
   logic [PW-1:0]          cur_ptr, ptr_clamp, ptr_next;
   logic [LENW-1:0]        ptr_inc;
   logic [LENW-1:0]        len_calc;
   logic [26:0]            len_prod;
   logic [12:0]            len_raw;
   logic signed [SB+1:0]   y_val;
   logic signed [SB+2:0]   diff;
   logic signed [SB+4:0]   s_sum;
   logic signed [SB+1:0]   w_sum;
   logic signed [SB:0]     lr_sum;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid;
   assign req_stall = !(state_ff == ST_IDLE && !len_pend_ff);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign load_out  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // pointer handling for the current line
   assign cur_ptr   = ptr_ff[idx_ff];
   assign ptr_clamp = (LENW'(cur_ptr) >= len_ff[idx_ff]) ? '0 : cur_ptr;
   assign ptr_inc   = LENW'(cur_ptr) + LENW'(1);
   assign ptr_next  = (ptr_inc >= len_ff[idx_ff]) ? '0 : ptr_inc[PW-1:0];

   // line length = base * scale >> 14, held to 1..MAX_LINE_DEPTH
   assign len_prod = 27'(line_base(idx_ff)) * 27'(scale_ff);
   assign len_raw  = len_prod[26:14];
   always_comb begin
      if (len_raw == '0)
         len_calc = LENW'(1);
      else if (32'(len_raw) > MAX_LINE_DEPTH)
         len_calc = LENW'(MAX_LINE_DEPTH);
      else
         len_calc = LENW'(len_raw);
   end

   // datapath: Householder output, lowpass, gain, write value
   assign y_val    = (SB+2)'(d_ff[idx_ff]) - (SB+2)'($signed(total_ff[SB+2:2]));
   assign diff     = (SB+3)'(y_val) - (SB+3)'(lp_ff[idx_ff]);
   assign prod1_in = $signed({1'b0, damp_ff}) * diff;
   assign s_sum    = (SB+5)'(lp_ff[idx_ff]) + (SB+5)'($signed(prod1_ff[43:16]));
   assign snew_in  = sat_sample(32'(s_sum));
   assign prod2_in = snew_ff * $signed({1'b0, gain_ff});
   assign w_sum    = (SB+2)'(mono_ff) + (SB+2)'($signed(prod2_ff[SB+16:16]));
   assign lr_sum   = (SB+1)'(req_data.left_in) + (SB+1)'(req_data.right_in);

   // memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = AW'(idx_ff) * AW'(MAX_LINE_DEPTH) + AW'(cur_ptr);
      mem_wdata = sat_sample(32'(w_sum));
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_addr  = clr_ff;
         mem_wdata = '0;
      end else if (state_ff == ST_READ) begin
         mem_re    = 1'b1;
         mem_addr  = AW'(idx_ff) * AW'(MAX_LINE_DEPTH) + AW'(ptr_clamp);
      end else if (state_ff == ST_WRITE) begin
         mem_we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_addr] <= mem_wdata;
      if (mem_re)
         mem_rdata_ff <= mem[mem_addr];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == AW'(MEM_DEPTH - 1)) state_in = ST_LEN;
         ST_LEN:    if (idx_ff == LINE_BITS'(NUM_LINES - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (len_pend_ff)
               state_in = ST_LEN;
            else if (accept)
               state_in = ST_READ;
         end
         ST_READ:   if (idx_ff == LINE_BITS'(NUM_LINES - 1)) state_in = ST_MIX;
         ST_MIX:    state_in = ST_DAMP;
         ST_DAMP:   state_in = ST_SMOOTH;
         ST_SMOOTH: state_in = ST_GAIN;
         ST_GAIN:   state_in = ST_WRITE;
         ST_WRITE:  state_in = (idx_ff == LINE_BITS'(NUM_LINES - 1)) ? ST_DONE : ST_DAMP;
         ST_DONE:   if (load_out) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      len_pend_in = len_pend_ff;
      if (state_ff == ST_LEN && idx_ff == LINE_BITS'(NUM_LINES - 1))
         len_pend_in = 1'b0;
      if (csr_we && csr_index == CSR_SIZE_SCALE)
         len_pend_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         idx_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         len_pend_ff  <= 1'b1;
         gain_ff      <= GAIN_RESET;
         damp_ff      <= DAMP_RESET;
         scale_ff     <= SCALE_RESET;
         stereo_ff    <= 1'b1;
         for (int i = 0; i < NUM_LINES; i++) begin
            ptr_ff[i] <= '0;
            lp_ff[i]  <= '0;
         end
      end else begin
         state_ff    <= state_in;
         len_pend_ff <= len_pend_in;

         if (csr_we) begin
            unique case (csr_index)
               CSR_FEEDBACK_GAIN: gain_ff   <= csr_data;
               CSR_DAMP_COEFF:    damp_ff   <= csr_data;
               CSR_SIZE_SCALE: begin
                  scale_ff <= csr_data;
                  for (int i = 0; i < NUM_LINES; i++)
                     ptr_ff[i] <= '0;
               end
               CSR_STEREO_MODE:   stereo_ff <= csr_data[0];
               default: ;
            endcase
         end

         if (state_ff == ST_CLEAR)
            clr_ff <= clr_ff + AW'(1);

         // line index walks 0..7 in LEN, READ and once per line in WRITE
         if (state_ff == ST_LEN || state_ff == ST_READ || state_ff == ST_WRITE)
            idx_ff <= idx_ff + LINE_BITS'(1);
         else if (state_ff == ST_IDLE || state_ff == ST_MIX)
            idx_ff <= '0;

         if (state_ff == ST_READ && !(csr_we && csr_index == CSR_SIZE_SCALE))
            ptr_ff[idx_ff] <= ptr_clamp;
         if (state_ff == ST_WRITE && !(csr_we && csr_index == CSR_SIZE_SCALE))
            ptr_ff[idx_ff] <= ptr_next;
         if (state_ff == ST_SMOOTH)
            lp_ff[idx_ff] <= snew_in;

         rd_pend_ff <= (state_ff == ST_READ);

         if (load_out)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_LEN)
         len_ff[idx_ff] <= len_calc;
      if (state_ff == ST_READ)
         rd_line_ff <= idx_ff;
      if (accept) begin
         total_ff <= '0;
         even_ff  <= '0;
         odd_ff   <= '0;
         mono_ff  <= stereo_ff ? lr_sum[SB:1]
                               : {req_data.left_in[SB-1], req_data.left_in[SB-1:1]};
      end else if (rd_pend_ff) begin
         d_ff[rd_line_ff] <= mem_rdata_ff;
         total_ff <= total_ff + (SB+3)'(mem_rdata_ff);
         if (rd_line_ff[0])
            odd_ff  <= odd_ff + (SB+2)'(mem_rdata_ff);
         else
            even_ff <= even_ff + (SB+2)'(mem_rdata_ff);
      end
      if (state_ff == ST_DAMP)
         prod1_ff <= prod1_in;
      if (state_ff == ST_SMOOTH)
         snew_ff <= snew_in;
      if (state_ff == ST_GAIN)
         prod2_ff <= prod2_in;
      if (load_out) begin
         rsp_data_ff.left_out  <= even_ff[SB+1:2];
         rsp_data_ff.right_out <= odd_ff[SB+1:2];
      end
   end

`ifndef SYNTH
   // one item in flight: an accept is never followed by another at once
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("item accepted while previous still in work");

   // no input taken before the memory sweep and length pass finish
   a_clear_blocks: assert property (@(posedge clock)
      (state_ff == ST_CLEAR || state_ff == ST_LEN) |-> req_stall)
      else $error("input open during clear or length pass");

   // write-back stays inside the line
   a_ptr_in_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (LENW'(cur_ptr) < len_ff[idx_ff]))
      else $error("write pointer beyond line length");

   // a finished result is never dropped while stalled
   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=> state_ff == ST_DONE)
      else $error("result loaded over a stalled one");
`endif

endmodule
